### src/lru_steal_slot_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef LRU_STEAL_SLOT_ALLOCATOR_ASSERT_SVH
`define LRU_STEAL_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define LSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsa: assertion failed");
// Check that a trigger is followed by a consequence in the next cycle.
`define LSA_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("lsa: sequencing assertion failed");
`else
`define LSA_ASSERT(lbl, prop)
`define LSA_ASSERT_NEXT(lbl, trig, cons)
`endif

`endif

### src/lsa_pkg.sv
package lsa_pkg;

  // Field widths of the beats and the limit register
  localparam int unsigned SlotW  = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned LimitW = 13;
  localparam int unsigned CfgAddrW = 3;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_ACTIVE_LIMIT = 1'b0;

  localparam logic [LimitW-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [LimitW-1:0] LIMIT_MIN   = 13'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SlotW-1:0] slot_index;
  } lsa_in_t;

  typedef struct packed {
    logic [SlotW-1:0]  granted_slot;
    logic              stole_oldest;
    logic              bad_free;
    logic [CountW-1:0] active_count;
  } lsa_out_t;

endpackage

### src/lsa_ram.sv
module lsa_ram #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/lru_steal_slot_allocator.sv
// Slot allocator over a pool of POOL_DEPTH slots: allocate pops the LIFO free list while a
// free slot exists and active count plus one stays below active_limit (0 and 1 act as 2),
// else it steals the oldest active slot; free unlinks an active slot and pushes it back;
// clear empties the pool. Every beat gives one result beat. One item is in work at a time,
// and the link memories are single-write-port RAMs stepped by a small sequencer: an
// allocate steps through unlink, link, a second link if the active list is not empty, and
// output; a free through unlink and output, active or not; a clear, an unknown code or a
// free of an index beyond the pool straight to output, which waits for the result register
// to drain. There is no clearing pass after reset or on clear: a high-water mark tells the
// slots never handed out since the last clear, which read as free in index order.
`include "lru_steal_slot_allocator_assert.svh"

module lru_steal_slot_allocator #(
  parameter int unsigned POOL_DEPTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lsa_pkg::lsa_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lsa_pkg::lsa_out_t                   out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsa_pkg::CfgAddrW-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned AddrW = $clog2(POOL_DEPTH);
  localparam int unsigned LinkW = AddrW + 1;
  localparam logic [LinkW-1:0] Nil = LinkW'(POOL_DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UNL  = 3'd1;
  localparam logic [2:0] S_LNK  = 3'd2;
  localparam logic [2:0] S_LNK2 = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Kind of work in progress
  localparam logic [1:0] MODE_POP   = 2'd0;
  localparam logic [1:0] MODE_STEAL = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [LinkW-1:0] slot_q, slot_d;
  logic [LinkW-1:0] free_head_q, free_head_d;
  logic [LinkW-1:0] newest_q, newest_d;
  logic [LinkW-1:0] oldest_q, oldest_d;
  logic [LinkW-1:0] hwm_q, hwm_d;
  logic [LinkW-1:0] live_q, live_d;
  logic [lsa_pkg::SlotW-1:0] res_granted_q, res_granted_d;
  logic             res_stole_q, res_stole_d;
  logic             res_bad_q, res_bad_d;
  logic [lsa_pkg::LimitW-1:0] limit_q;
  logic             out_valid_q, out_valid_d;
  lsa_pkg::lsa_out_t out_q, out_d;

  logic             in_acc;
  logic             idx_ok;
  logic [LinkW-1:0] idx_w;
  logic [lsa_pkg::LimitW-1:0] lim_eff;
  logic             can_pop;
  logic [LinkW-1:0] acc_slot;
  logic             fresh;
  logic             act;
  logic [LinkW-1:0] fn;
  logic [LinkW-1:0] n_link, o_link;
  logic             out_free;
  logic             cfg_wr;

  // Link memory ports
  logic             fnext_we, newer_we, older_we, active_we;
  logic [AddrW-1:0] fnext_waddr, newer_waddr, older_waddr, active_waddr;
  logic [LinkW-1:0] fnext_wdata, newer_wdata, older_wdata;
  logic             active_wdata;
  logic [AddrW-1:0] fnext_raddr, link_raddr;
  logic [LinkW-1:0] fnext_rdata, newer_rdata, older_rdata;
  logic             active_rdata;

  lsa_ram #(.Width(LinkW), .Depth(POOL_DEPTH)) u_fnext (
    .clk_i, .we_i(fnext_we), .waddr_i(fnext_waddr), .wdata_i(fnext_wdata),
    .re_i(in_acc), .raddr_i(fnext_raddr), .rdata_o(fnext_rdata)
  );

  lsa_ram #(.Width(LinkW), .Depth(POOL_DEPTH)) u_newer (
    .clk_i, .we_i(newer_we), .waddr_i(newer_waddr), .wdata_i(newer_wdata),
    .re_i(in_acc), .raddr_i(link_raddr), .rdata_o(newer_rdata)
  );

  lsa_ram #(.Width(LinkW), .Depth(POOL_DEPTH)) u_older (
    .clk_i, .we_i(older_we), .waddr_i(older_waddr), .wdata_i(older_wdata),
    .re_i(in_acc), .raddr_i(link_raddr), .rdata_o(older_rdata)
  );

  lsa_ram #(.Width(1), .Depth(POOL_DEPTH)) u_active (
    .clk_i, .we_i(active_we), .waddr_i(active_waddr), .wdata_i(active_wdata),
    .re_i(in_acc), .raddr_i(link_raddr), .rdata_o(active_rdata)
  );

  // Input handshake and decisions taken at accept
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_ok     = 32'(in_data_i.slot_index) < POOL_DEPTH;
  assign idx_w      = LinkW'(in_data_i.slot_index);
  assign lim_eff    = (limit_q < lsa_pkg::LIMIT_MIN) ? lsa_pkg::LIMIT_MIN : limit_q;
  assign can_pop    = (free_head_q < Nil) && ((32'(live_q) + 32'd1) < 32'(lim_eff));

  always_comb begin
    case (in_data_i.operation)
      lsa_pkg::OP_ALLOC: acc_slot = can_pop ? free_head_q : oldest_q;
      lsa_pkg::OP_FREE:  acc_slot = idx_w;
      default:           acc_slot = '0;
    endcase
  end

  assign fnext_raddr = free_head_q[AddrW-1:0];
  assign link_raddr  = acc_slot[AddrW-1:0];

  // Read data: slots at or above the high-water mark are untouched since the last clear
  assign fresh  = (slot_q >= hwm_q);
  assign act    = !fresh && active_rdata;
  assign fn     = fresh ? (slot_q + LinkW'(1)) : fnext_rdata;
  assign n_link = newer_rdata;
  assign o_link = older_rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  // Memory writes per sequencer step
  always_comb begin
    fnext_we     = 1'b0;
    fnext_waddr  = slot_q[AddrW-1:0];
    fnext_wdata  = free_head_q;
    newer_we     = 1'b0;
    newer_waddr  = slot_q[AddrW-1:0];
    newer_wdata  = Nil;
    older_we     = 1'b0;
    older_waddr  = slot_q[AddrW-1:0];
    older_wdata  = newest_q;
    active_we    = 1'b0;
    active_waddr = slot_q[AddrW-1:0];
    active_wdata = 1'b0;
    unique case (state_q)
      S_UNL: begin
        if ((mode_q == MODE_STEAL) || ((mode_q == MODE_FREE) && act)) begin
          // Unlink: bridge the neighbors around the slot
          if (n_link < Nil) begin
            older_we    = 1'b1;
            older_waddr = n_link[AddrW-1:0];
            older_wdata = o_link;
          end
          if (o_link < Nil) begin
            newer_we    = 1'b1;
            newer_waddr = o_link[AddrW-1:0];
            newer_wdata = n_link;
          end
        end
        if ((mode_q == MODE_FREE) && act) begin
          active_we = 1'b1;
          fnext_we  = 1'b1;
        end
        if (mode_q == MODE_POP) begin
          active_we    = 1'b1;
          active_wdata = 1'b1;
        end
      end
      S_LNK: begin
        // Link as newest: point back at the old newest, nothing newer
        older_we = 1'b1;
        newer_we = 1'b1;
      end
      S_LNK2: begin
        newer_we    = 1'b1;
        newer_waddr = newest_q[AddrW-1:0];
        newer_wdata = slot_q;
      end
      S_IDLE, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    slot_d        = slot_q;
    free_head_d   = free_head_q;
    newest_d      = newest_q;
    oldest_d      = oldest_q;
    hwm_d         = hwm_q;
    live_d        = live_q;
    res_granted_d = res_granted_q;
    res_stole_d   = res_stole_q;
    res_bad_d     = res_bad_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_granted_d = '0;
          res_stole_d   = 1'b0;
          res_bad_d     = 1'b0;
          slot_d        = acc_slot;
          state_d       = S_OUT;
          case (in_data_i.operation)
            lsa_pkg::OP_ALLOC: begin
              if (can_pop) begin
                mode_d  = MODE_POP;
                state_d = S_UNL;
              end else if (oldest_q < Nil) begin
                mode_d  = MODE_STEAL;
                state_d = S_UNL;
              end
            end
            lsa_pkg::OP_FREE: begin
              if (idx_ok) begin
                mode_d  = MODE_FREE;
                state_d = S_UNL;
              end else begin
                res_bad_d = 1'b1;
              end
            end
            lsa_pkg::OP_CLEAR: begin
              free_head_d = '0;
              newest_d    = Nil;
              oldest_d    = Nil;
              hwm_d       = '0;
              live_d      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UNL: begin
        unique case (mode_q)
          MODE_POP: begin
            free_head_d = fn;
            if (fresh) begin
              hwm_d = slot_q + LinkW'(1);
            end
            live_d  = live_q + LinkW'(1);
            state_d = S_LNK;
          end
          MODE_STEAL: begin
            if (n_link >= Nil) newest_d = o_link;
            if (o_link >= Nil) oldest_d = n_link;
            res_stole_d = 1'b1;
            state_d     = S_LNK;
          end
          MODE_FREE: begin
            if (act) begin
              if (n_link >= Nil) newest_d = o_link;
              if (o_link >= Nil) oldest_d = n_link;
              free_head_d = slot_q;
              if (live_q != '0) begin
                live_d = live_q - LinkW'(1);
              end
            end else begin
              res_bad_d = 1'b1;
            end
            state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_LNK: begin
        res_granted_d = lsa_pkg::SlotW'(slot_q);
        if (newest_q < Nil) begin
          state_d = S_LNK2;
        end else begin
          oldest_d = slot_q;
          newest_d = slot_q;
          state_d  = S_OUT;
        end
      end
      S_LNK2: begin
        newest_d = slot_q;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.granted_slot = res_granted_q;
          out_d.stole_oldest = res_stole_q;
          out_d.bad_free     = res_bad_q;
          out_d.active_count = lsa_pkg::CountW'(live_q);
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_POP;
      free_head_q <= '0;
      newest_q    <= Nil;
      oldest_q    <= Nil;
      hwm_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      free_head_q <= free_head_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      hwm_q       <= hwm_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q        <= slot_d;
    res_granted_q <= res_granted_d;
    res_stole_q   <= res_stole_d;
    res_bad_q     <= res_bad_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lsa_pkg::LIMIT_RESET;
    end else if (cfg_wr && (paddr[2] == lsa_pkg::REG_ACTIVE_LIMIT)) begin
      limit_q <= pwdata[lsa_pkg::LimitW-1:0];
    end
  end

  assign prdata = (paddr[2] == lsa_pkg::REG_ACTIVE_LIMIT) ? 32'(limit_q) : 32'd0;

  // Assertions
  `LSA_ASSERT(a_ends_agree, (state_q == S_IDLE) |-> ((newest_q == Nil) == (oldest_q == Nil)))
  `LSA_ASSERT(a_empty_list, (state_q == S_IDLE) |-> ((live_q == '0) == (newest_q == Nil)))
  `LSA_ASSERT(a_count_bound, (live_q <= hwm_q) && (hwm_q <= Nil))
  `LSA_ASSERT(a_out_load, $rose(out_valid_q) |-> $past(state_q == S_OUT))
  `LSA_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE)

endmodule
